### design/contact_collision_force_core_defines.svh
// Assertion macros shared by the contact force design.
// Define NO_ASSERTIONS to compile them away.
`ifndef CONTACT_COLLISION_FORCE_CORE_DEFINES_SVH
`define CONTACT_COLLISION_FORCE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CCF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contact force check failed");
`define CCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contact force check failed");
`else
`define CCF_ASSERT_SAME(label, ante, cons)
`define CCF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/ccf_pkg.sv
package ccf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int CFG_W      = 31;
	localparam int DOT_W      = 66;
	localparam int NUM_W      = 98;
	localparam int MAG_W      = 97;
	localparam int M_W        = 128;
	localparam int DEN_W      = 64 + FRAC_BITS;
	localparam int QUO_W      = 32;
	localparam int DIV_STAGES = QUO_W;

	typedef logic signed [DATA_W-1:0] coord_t;

	typedef enum logic [1:0] {
		REG_RADIUS    = 2'd0,
		REG_DAMPING   = 2'd1,
		REG_REPULSION = 2'd2
	} cfg_reg_t;

	// Control that travels beside the data through the pipeline.
	typedef struct packed {
		logic valid;
		logic contact;
	} ctl_t;

	// One force component handed to its divider.
	typedef struct packed {
		logic [M_W-1:0]   num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             ovf;
	} div_in_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} div_out_t;

endpackage

### design/ccf_front.sv
module ccf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  ccf_pkg::coord_t [2:0]    a_pos,
	input  ccf_pkg::coord_t [2:0]    b_pos,
	input  ccf_pkg::coord_t [2:0]    a_vel,
	input  ccf_pkg::coord_t [2:0]    b_vel,
	input  logic [ccf_pkg::CFG_W-1:0] radius,
	input  logic [ccf_pkg::CFG_W-1:0] damping,
	input  logic [ccf_pkg::CFG_W-1:0] repulsion,
	output ccf_pkg::ctl_t            ctl,
	output ccf_pkg::div_in_t [2:0]   div_in
);
	import ccf_pkg::*;

	logic signed [32:0] r_s1 [3];
	logic signed [32:0] dv_s1 [3];
	logic [30:0] rmag_s2 [3];
	logic [32:0] dvm_s2 [3];
	logic [2:0] rs_s2, dvs_s2;
	logic far_s2;
	logic [61:0] sq_s3 [3];
	logic [63:0] pr_s3 [3];
	logic [2:0] ps_s3, rs_s3;
	logic [30:0] rmag_s3 [3];
	logic far_s3;
	logic [61:0] radsq_s3;
	logic [63:0] q_s4;
	logic signed [DOT_W-1:0] dot_s4;
	logic far_s4;
	logic [61:0] radsq_s4;
	logic [2:0] rs_s4;
	logic [30:0] rmag_s4 [3];
	logic contact_s5, dotneg_s5;
	logic [DOT_W-2:0] dotmag_s5;
	logic [63:0] q_s5;
	logic [2:0] rs_s5;
	logic [30:0] rmag_s5 [3];
	logic [63:0] ppl_s6;
	logic [62:0] pph_s6;
	logic contact_s6, dotneg_s6;
	logic [63:0] q_s6;
	logic [2:0] rs_s6;
	logic [30:0] rmag_s6 [3];
	logic [95:0] cd_s7;
	logic contact_s7, dotneg_s7;
	logic [63:0] q_s7;
	logic [2:0] rs_s7;
	logic [30:0] rmag_s7 [3];
	logic [NUM_W-1:0] t_s8;
	logic contact_s8, dotneg_s8;
	logic [63:0] q_s8;
	logic [2:0] rs_s8;
	logic [30:0] rmag_s8 [3];
	logic [MAG_W-1:0] nmag_s9;
	logic nneg_s9, contact_s9;
	logic [63:0] q_s9;
	logic [2:0] rs_s9;
	logic [30:0] rmag_s9 [3];
	logic [63:0] mp0_s10 [3];
	logic [63:0] mp1_s10 [3];
	logic [61:0] mp2_s10 [3];
	logic [2:0] neg_s10;
	logic [DEN_W-1:0] den_s10;
	logic contact_s10;
	logic [M_W-1:0] m_s11 [3];
	logic [2:0] neg_s11;
	logic [DEN_W-1:0] den_s11;
	logic contact_s11;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic contact_s12;
	div_in_t [2:0] div_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {in_valid, v_s1, v_s2, v_s3, v_s4, v_s5};
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= {v_s6, v_s7, v_s8, v_s9, v_s10, v_s11};
		end
	end

	always_ff @(posedge clk) begin
		logic far;
		logic [32:0] mag;
		logic [63:0] qs;
		logic signed [DOT_W-1:0] ds, tv;
		logic [NUM_W-1:0] cde, ks;
		if (en) begin
			// Stage 1: separation and relative velocity.
			for (int i = 0; i < 3; i++) begin
				r_s1[i]  <= 33'(b_pos[i]) - 33'(a_pos[i]);
				dv_s1[i] <= 33'(b_vel[i]) - 33'(a_vel[i]);
			end
			// Stage 2: magnitudes and the per-axis radius test.
			far = 1'b0;
			for (int i = 0; i < 3; i++) begin
				mag = r_s1[i][32] ? 33'(-r_s1[i]) : 33'(r_s1[i]);
				far = far | (mag > {2'b00, radius});
				rmag_s2[i] <= mag[30:0];
				rs_s2[i]   <= r_s1[i][32];
				dvm_s2[i]  <= dv_s1[i][32] ? 33'(-dv_s1[i]) : 33'(dv_s1[i]);
				dvs_s2[i]  <= dv_s1[i][32];
			end
			far_s2 <= far;
			// Stage 3: squares and velocity products.
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 62'(rmag_s2[i]) * 62'(rmag_s2[i]);
				pr_s3[i] <= 64'(dvm_s2[i]) * 64'(rmag_s2[i]);
			end
			ps_s3    <= dvs_s2 ^ rs_s2;
			rs_s3    <= rs_s2;
			rmag_s3  <= rmag_s2;
			far_s3   <= far_s2;
			radsq_s3 <= 62'(radius) * 62'(radius);
			// Stage 4: squared distance and signed dot product.
			qs = '0;
			ds = '0;
			for (int i = 0; i < 3; i++) begin
				qs = qs + 64'(sq_s3[i]);
				tv = {2'b00, pr_s3[i]};
				ds = ps_s3[i] ? ds - tv : ds + tv;
			end
			q_s4     <= qs;
			dot_s4   <= ds;
			far_s4   <= far_s3;
			radsq_s4 <= radsq_s3;
			rs_s4    <= rs_s3;
			rmag_s4  <= rmag_s3;
			// Stage 5: contact decision and dot magnitude.
			contact_s5 <= !far_s4 && (q_s4 <= 64'(radsq_s4)) && (q_s4 != '0);
			dotneg_s5  <= dot_s4[DOT_W-1];
			dotmag_s5  <= dot_s4[DOT_W-1] ? (DOT_W-1)'(-dot_s4) : dot_s4[DOT_W-2:0];
			q_s5       <= q_s4;
			rs_s5      <= rs_s4;
			rmag_s5    <= rmag_s4;
			// Stage 6: damping gain times the dot product, in two halves.
			ppl_s6     <= 64'(damping) * 64'(dotmag_s5[32:0]);
			pph_s6     <= 63'(damping) * 63'(dotmag_s5[64:33]);
			contact_s6 <= contact_s5;
			dotneg_s6  <= dotneg_s5;
			q_s6       <= q_s5;
			rs_s6      <= rs_s5;
			rmag_s6    <= rmag_s5;
			// Stage 7: join the halves.
			cd_s7      <= 96'(ppl_s6) + (96'(pph_s6) << 33);
			contact_s7 <= contact_s6;
			dotneg_s7  <= dotneg_s6;
			q_s7       <= q_s6;
			rs_s7      <= rs_s6;
			rmag_s7    <= rmag_s6;
			// Stage 8: subtract the repulsion term.
			cde = NUM_W'(cd_s7);
			ks  = NUM_W'(repulsion) << (2 * FRAC_BITS);
			t_s8       <= dotneg_s7 ? cde + ks : cde - ks;
			contact_s8 <= contact_s7;
			dotneg_s8  <= dotneg_s7;
			q_s8       <= q_s7;
			rs_s8      <= rs_s7;
			rmag_s8    <= rmag_s7;
			// Stage 9: numerator as sign and magnitude.
			nneg_s9    <= dotneg_s8 | t_s8[NUM_W-1];
			nmag_s9    <= (!dotneg_s8 && t_s8[NUM_W-1]) ? MAG_W'(-t_s8) : t_s8[MAG_W-1:0];
			contact_s9 <= contact_s8;
			q_s9       <= q_s8;
			rs_s9      <= rs_s8;
			rmag_s9    <= rmag_s8;
			// Stage 10: numerator times each separation component.
			for (int i = 0; i < 3; i++) begin
				mp0_s10[i] <= 64'(nmag_s9[32:0]) * 64'(rmag_s9[i]);
				mp1_s10[i] <= 64'(nmag_s9[65:33]) * 64'(rmag_s9[i]);
				mp2_s10[i] <= 62'(nmag_s9[96:66]) * 62'(rmag_s9[i]);
			end
			neg_s10     <= {3{nneg_s9}} ^ rs_s9;
			den_s10     <= DEN_W'(q_s9) << FRAC_BITS;
			contact_s10 <= contact_s9;
			// Stage 11: sum the partial products.
			for (int i = 0; i < 3; i++)
				m_s11[i] <= M_W'(mp0_s10[i]) + (M_W'(mp1_s10[i]) << 33)
					+ (M_W'(mp2_s10[i]) << 66);
			neg_s11     <= neg_s10;
			den_s11     <= den_s10;
			contact_s11 <= contact_s10;
			// Stage 12: flag quotients that cannot fit in 32 bits.
			for (int i = 0; i < 3; i++) begin
				div_s12[i].num <= m_s11[i];
				div_s12[i].den <= den_s11;
				div_s12[i].neg <= neg_s11[i];
				div_s12[i].ovf <= m_s11[i] >= (M_W'(den_s11) << QUO_W);
			end
			contact_s12 <= contact_s11;
		end
	end

	always_comb begin
		ctl.valid   = v_s12;
		ctl.contact = contact_s12;
	end
	assign div_in = div_s12;

endmodule

### design/ccf_div.sv
module ccf_div (
	input  logic              clk,
	input  logic              en,
	input  ccf_pkg::div_in_t  din,
	output ccf_pkg::div_out_t dout
);
	import ccf_pkg::*;

	// Restoring division, one quotient bit per stage, most significant first.
	// Entry k holds the beat after stage k has resolved its bit.
	logic [M_W-1:0]   rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];
	logic             neg_s [DIV_STAGES];
	logic             ovf_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		logic [M_W-1:0] sh;
		logic           ge;
		if (en) begin
			sh = M_W'(din.den) << (DIV_STAGES - 1);
			ge = din.num >= sh;
			rem_s[0] <= ge ? din.num - sh : din.num;
			quo_s[0] <= QUO_W'(ge);
			den_s[0] <= din.den;
			neg_s[0] <= din.neg;
			ovf_s[0] <= din.ovf;
			for (int k = 1; k < DIV_STAGES; k++) begin
				sh = M_W'(den_s[k-1]) << (DIV_STAGES - 1 - k);
				ge = rem_s[k-1] >= sh;
				rem_s[k] <= ge ? rem_s[k-1] - sh : rem_s[k-1];
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign dout.quo = quo_s[DIV_STAGES-1];
	assign dout.neg = neg_s[DIV_STAGES-1];
	assign dout.ovf = ovf_s[DIV_STAGES-1];

endmodule

### design/contact_collision_force_core.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  a/b positions and velocities, 12 x 32 bits
// out       output     out_valid/out_stall  force_x/y/z, in_contact, saturated
// cfg       input      cfg_valid/cfg_ready  cfg_index (2 bits), cfg_data (32 bits)
//
// The block takes one beat per cycle while no result is held at the output.
// A beat passes 45 register stages: twelve front stages (differences,
// products, the numerator), thirty-two divider stages that each resolve
// one quotient bit, and the output register. The reset is asynchronous
// and active low; it clears the valid bits and loads the register defaults.
// A stall on the output while a result is offered freezes every stage at
// once, so the input is stalled in the same cycle and no beat is lost.
module contact_collision_force_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ccf_pkg::coord_t      a_pos_x,
	input  ccf_pkg::coord_t      a_pos_y,
	input  ccf_pkg::coord_t      a_pos_z,
	input  ccf_pkg::coord_t      b_pos_x,
	input  ccf_pkg::coord_t      b_pos_y,
	input  ccf_pkg::coord_t      b_pos_z,
	input  ccf_pkg::coord_t      a_vel_x,
	input  ccf_pkg::coord_t      a_vel_y,
	input  ccf_pkg::coord_t      a_vel_z,
	input  ccf_pkg::coord_t      b_vel_x,
	input  ccf_pkg::coord_t      b_vel_y,
	input  ccf_pkg::coord_t      b_vel_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ccf_pkg::coord_t      force_x,
	output ccf_pkg::coord_t      force_y,
	output ccf_pkg::coord_t      force_z,
	output logic                 in_contact,
	output logic                 saturated,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [ccf_pkg::DATA_W-1:0] cfg_data
);
	import ccf_pkg::*;

	`include "contact_collision_force_core_defines.svh"

	logic [CFG_W-1:0] radius_q, damping_q, repulsion_q;
	logic             en;
	ctl_t             front_ctl;
	div_in_t [2:0]    div_in;
	div_out_t [2:0]   div_out;
	ctl_t             ctl_s [DIV_STAGES];
	coord_t           force_q [3];
	logic             valid_q, contact_q, sat_q;

	// The whole pipeline advances unless a finished beat is held at the output.
	assign en        = !(valid_q && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Register writes must arrive only while the pipeline is empty; no check enforces it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= CFG_W'(1 << FRAC_BITS);
			damping_q   <= '0;
			repulsion_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS:    radius_q    <= cfg_data[CFG_W-1:0];
				REG_DAMPING:   damping_q   <= cfg_data[CFG_W-1:0];
				REG_REPULSION: repulsion_q <= cfg_data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	ccf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.a_pos     ({a_pos_z, a_pos_y, a_pos_x}),
		.b_pos     ({b_pos_z, b_pos_y, b_pos_x}),
		.a_vel     ({a_vel_z, a_vel_y, a_vel_x}),
		.b_vel     ({b_vel_z, b_vel_y, b_vel_x}),
		.radius    (radius_q),
		.damping   (damping_q),
		.repulsion (repulsion_q),
		.ctl       (front_ctl),
		.div_in    (div_in)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		ccf_div u_div (
			.clk  (clk),
			.en   (en),
			.din  (div_in[i]),
			.dout (div_out[i])
		);
	end

	// Valid and contact ride alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				ctl_s[k] <= '0;
		end else if (en) begin
			ctl_s[0] <= front_ctl;
			for (int k = 1; k < DIV_STAGES; k++)
				ctl_s[k] <= ctl_s[k-1];
		end
	end

	// Output register: sign, saturation and the no-contact case.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s[DIV_STAGES-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		logic any_sat;
		logic contact;
		if (en) begin
			any_sat = 1'b0;
			contact = ctl_s[DIV_STAGES-1].contact;
			for (int i = 0; i < 3; i++) begin
				if (!contact) begin
					force_q[i] <= '0;
				end else if (div_out[i].neg) begin
					if (div_out[i].ovf || (div_out[i].quo > 32'h8000_0000)) begin
						force_q[i] <= 32'sh8000_0000;
						any_sat = 1'b1;
					end else begin
						force_q[i] <= coord_t'(-div_out[i].quo);
					end
				end else begin
					if (div_out[i].ovf || div_out[i].quo[QUO_W-1]) begin
						force_q[i] <= 32'sh7FFF_FFFF;
						any_sat = 1'b1;
					end else begin
						force_q[i] <= coord_t'(div_out[i].quo);
					end
				end
			end
			contact_q <= contact;
			sat_q     <= contact && any_sat;
		end
	end

	assign out_valid  = valid_q;
	assign force_x    = force_q[0];
	assign force_y    = force_q[1];
	assign force_z    = force_q[2];
	assign in_contact = contact_q;
	assign saturated  = sat_q;

	`CCF_ASSERT_SAME(a_sat_needs_contact, out_valid && saturated, in_contact)
	`CCF_ASSERT_SAME(a_no_contact_zero, out_valid && !in_contact,
		force_x == '0 && force_y == '0 && force_z == '0)
	`CCF_ASSERT_SAME(a_stall_only_when_held, in_stall, out_valid && out_stall)
	`CCF_ASSERT_NEXT(a_out_held, out_valid && out_stall,
		out_valid && $stable(force_x) && $stable(force_y) && $stable(force_z))

endmodule

### test/contact_force_checker.sv
`timescale 1ns / 100ps

module contact_force_checker
	import ccf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [11:0][31:0]  in_beat,
	input  logic               out_valid,
	input  logic               out_stall,
	input  coord_t             force_x,
	input  coord_t             force_y,
	input  coord_t             force_z,
	input  logic               in_contact,
	input  logic               saturated,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  cfg_reg_t           cfg_index,
	input  logic [DATA_W-1:0]  cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		coord_t fx;
		coord_t fy;
		coord_t fz;
		logic   contact;
		logic   sat;
	} force_t;

	logic [CFG_W-1:0] radius;
	logic [CFG_W-1:0] damping;
	logic [CFG_W-1:0] repulsion;
	force_t           awaited_forces[$];

	// Exact force on particle a for one beat, from the current register values.
	function automatic force_t predict_force(input logic [11:0][31:0] v);
		force_t             f;
		logic signed [127:0] r[3];
		logic signed [127:0] dv[3];
		logic signed [127:0] dot;
		logic signed [127:0] num;
		logic signed [127:0] cg;
		logic signed [127:0] kg;
		logic [127:0]        rm[3];
		logic [127:0]        q;
		logic [127:0]        rad;
		logic [127:0]        nmag;
		logic [127:0]        m;
		logic [127:0]        den;
		logic [127:0]        quo;
		logic [31:0]         comp[3];
		logic                far;
		logic                neg;
		f = '0;
		rad = radius;
		far = 1'b0;
		q = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = $signed(v[3+i]) - $signed(v[i]);
			dv[i] = $signed(v[9+i]) - $signed(v[6+i]);
			rm[i] = (r[i] < 0) ? -r[i] : r[i];
			if (rm[i] > rad)
				far = 1'b1;
		end
		if (far)
			return f;
		for (int i = 0; i < 3; i++)
			q += rm[i] * rm[i];
		if (q > rad * rad || q == 0)
			return f;
		dot = 0;
		for (int i = 0; i < 3; i++)
			dot += dv[i] * r[i];
		cg = damping;
		kg = repulsion;
		num = dot * cg - (kg <<< (2 * FRAC_BITS));
		nmag = (num < 0) ? -num : num;
		den = q << FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			m = nmag * rm[i];
			if (m >= (den << 32))
				quo = 128'h1_0000_0000;
			else
				quo = m / den;
			neg = (num < 0) != (r[i] < 0);
			if (neg) begin
				if (quo > 128'h8000_0000) begin
					quo = 128'h8000_0000;
					f.sat = 1'b1;
				end
				comp[i] = 32'd0 - quo[31:0];
			end else begin
				if (quo > 128'h7FFF_FFFF) begin
					quo = 128'h7FFF_FFFF;
					f.sat = 1'b1;
				end
				comp[i] = quo[31:0];
			end
		end
		f.fx = comp[0];
		f.fy = comp[1];
		f.fz = comp[2];
		f.contact = 1'b1;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius <= 31'd65536;
			damping <= '0;
			repulsion <= '0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			force_t got;
			force_t want;
			if (out_valid && !out_stall) begin
				got = '{force_x, force_y, force_z, in_contact, saturated};
				if (awaited_forces.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: unexpected result beat %h", $time, got);
				end else begin
					want = awaited_forces.pop_front();
					if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz ||
					    got.contact !== want.contact || got.sat !== want.sat) begin
						fail_count <= fail_count + 1;
						$display("%0t: force x/y/z contact sat expected %h %h %h %b %b got %h %h %h %b %b",
							$time, want.fx, want.fy, want.fz, want.contact, want.sat,
							got.fx, got.fy, got.fz, got.contact, got.sat);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_forces.push_back(predict_force(in_beat));
			pending <= awaited_forces.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RADIUS:    radius <= cfg_data[CFG_W-1:0];
					REG_DAMPING:   damping <= cfg_data[CFG_W-1:0];
					REG_REPULSION: repulsion <= cfg_data[CFG_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ccf_pkg::*;

	// The block has a 45 stage pipeline; the settle wait after a drain is longer still.
	localparam int       SETTLE_CYCLES = 60;
	localparam int       CYCLE_LIMIT   = 400000;
	localparam cfg_reg_t REG_SPARE     = cfg_reg_t'(2'd3);

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [11:0][31:0] in_beat;
	logic              out_valid;
	logic              out_stall;
	coord_t            force_x;
	coord_t            force_y;
	coord_t            force_z;
	logic              in_contact;
	logic              saturated;
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_reg_t          cfg_index;
	logic [31:0]       cfg_data;
	int                fail_count;
	int                pending;

	// The stimulus side keeps its own copy of the radius to aim particle pairs.
	logic [30:0]       radius_now;
	int                burst_left;
	int                cycles;
	int                hold_req;

	contact_collision_force_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_pos_x    (in_beat[0]),
		.a_pos_y    (in_beat[1]),
		.a_pos_z    (in_beat[2]),
		.b_pos_x    (in_beat[3]),
		.b_pos_y    (in_beat[4]),
		.b_pos_z    (in_beat[5]),
		.a_vel_x    (in_beat[6]),
		.a_vel_y    (in_beat[7]),
		.a_vel_z    (in_beat[8]),
		.b_vel_x    (in_beat[9]),
		.b_vel_y    (in_beat[10]),
		.b_vel_z    (in_beat[11]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.force_x    (force_x),
		.force_y    (force_y),
		.force_z    (force_z),
		.in_contact (in_contact),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	contact_force_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.force_x    (force_x),
		.force_y    (force_y),
		.force_z    (force_z),
		.in_contact (in_contact),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that hangs is a failure on its own.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("contact_collision_force_core: mismatch");
			$finish;
		end
	end

	// The receiver switches between stall patterns at random: no stall,
	// light stalls and heavy stalls. When a long hold-off is requested it
	// stalls solidly so that the pipeline fills and backs up.
	initial begin
		int mode;
		int hold_left;
		int phase_cnt;
		mode = 0;
		hold_left = 0;
		phase_cnt = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_req = 0;
				hold_left = 300;
			end
			phase_cnt++;
			if (phase_cnt == 64) begin
				phase_cnt = 0;
				mode = $urandom_range(0, 2);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 4) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Offers one beat and holds it until the block takes it. Beats go out in
	// bursts of random length, and between bursts the valid drops for a
	// random number of cycles, sometimes none at all.
	task automatic send_beat(input logic [11:0][31:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_beat <= v;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// Stops offering beats until every result is back and the pipeline is empty.
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_RADIUS)
			radius_now = value[30:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Builds a particle pair. Most pairs sit within reach of the radius so
	// that the force path is exercised; a few are fully random noise, and a
	// few put one axis exactly on the radius.
	function automatic logic [11:0][31:0] make_pair();
		logic [11:0][31:0] v;
		logic [31:0]       lim;
		logic [31:0]       off;
		int                kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 12; i++)
			v[i] = $urandom;
		if (kind < 2)
			return v;
		lim = radius_now / 2 + 2;
		for (int i = 0; i < 3; i++) begin
			off = (kind == 9 && i == 0) ? {1'b0, radius_now} : $urandom_range(0, lim);
			if ($urandom_range(0, 1))
				off = -off;
			v[3+i] = v[i] + off;
		end
		if (kind >= 5)
			for (int i = 6; i < 12; i++)
				v[i] = $signed(20'($urandom));
		return v;
	endfunction

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_beat(make_pair());
			// Now and then the sender waits for every result before going on.
			if ($urandom_range(0, 59) == 0)
				drain();
		end
	endtask

	initial begin
		logic [11:0][31:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		radius_now = 31'd65536;
		burst_left = 0;
		cycles = 0;
		hold_req = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults: radius 1.0 and both gains zero, so contact gives
		// zero force with in_contact set. Coincident, on the boundary, just
		// beyond it, and well inside.
		v = '0;
		send_beat(v);
		v[3] = 32'd65536;
		send_beat(v);
		v[3] = 32'd65537;
		send_beat(v);
		v[3] = 32'd0;
		v[5] = -32'sd30000;
		v[9] = 32'h7FFF_FFFF;
		send_beat(v);
		drain();

		write_reg(REG_RADIUS, 32'd262144);
		write_reg(REG_DAMPING, 32'd32768);
		write_reg(REG_REPULSION, 32'd131072);

		// Boundary on a negative axis, a diagonal pair outside the sphere while
		// each axis is inside, and extreme coordinates far apart.
		v = '0;
		v[2] = 32'd262144;
		v[7] = 32'h0001_0000;
		send_beat(v);
		v = '0;
		v[3] = 32'd200000;
		v[4] = 32'd200000;
		v[5] = 32'd200000;
		send_beat(v);
		v = '0;
		v[0] = 32'h8000_0000;
		v[1] = 32'h8000_0000;
		v[2] = 32'h8000_0000;
		v[3] = 32'h7FFF_FFFF;
		v[4] = 32'h7FFF_FFFF;
		v[5] = 32'h7FFF_FFFF;
		send_beat(v);
		// Coincident at the top corner with extreme velocities.
		for (int i = 0; i < 6; i++)
			v[i] = 32'h7FFF_FFFF;
		for (int i = 6; i < 12; i++)
			v[i] = (i < 9) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send_beat(v);
		// One LSB apart with extreme velocities: the force clips.
		v[3] = 32'h7FFF_FFFE;
		send_beat(v);
		for (int i = 6; i < 12; i++)
			v[i] = (i < 9) ? 32'h7FFF_FFFF : 32'h8000_0000;
		send_beat(v);
		// Small separations with mixed signs, repulsion dominated.
		v = '0;
		v[3] = -32'sd1;
		send_beat(v);
		v[3] = 32'd1000;
		v[4] = -32'sd2000;
		v[5] = 32'd3000;
		v[10] = -32'sd65536;
		send_beat(v);
		v[0] = 32'h8000_0000;
		v[3] = 32'h8000_0000 + 32'd100000;
		v[6] = 32'h8000_0000;
		send_beat(v);
		run_random(140);
		drain();

		// Largest radius and gains; the receiver holds off for a long stretch.
		write_reg(REG_RADIUS, 32'h7FFF_FFFF);
		write_reg(REG_DAMPING, 32'h7FFF_FFFF);
		write_reg(REG_REPULSION, 32'h7FFF_FFFF);
		hold_req = 1;
		run_random(60);
		drain();

		// Zero radius: nothing is ever in contact.
		write_reg(REG_RADIUS, 32'd0);
		write_reg(REG_DAMPING, $urandom);
		write_reg(REG_REPULSION, $urandom);
		run_random(20);
		drain();

		write_reg(REG_RADIUS, 32'd1048576);
		write_reg(REG_DAMPING, 32'd0);
		write_reg(REG_REPULSION, $urandom_range(0, 32'h0004_0000));
		run_random(80);
		drain();

		write_reg(REG_RADIUS, $urandom);
		write_reg(REG_DAMPING, $urandom);
		write_reg(REG_REPULSION, 32'd0);
		run_random(80);
		drain();

		// The top data bit is ignored, and the spare index writes nothing.
		write_reg(REG_RADIUS, 32'h8002_0000);
		write_reg(REG_DAMPING, 32'h8000_0000 | $urandom_range(0, 32'h0010_0000));
		write_reg(REG_REPULSION, $urandom_range(0, 32'h0010_0000));
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		run_random(110);

		drain();
		if (fail_count == 0)
			$display("contact_collision_force_core: match");
		else
			$display("contact_collision_force_core: mismatch");
		$finish;
	end

endmodule
